### rtl/core/jdv_pkg.sv
package jdv_pkg;

    // Stack geometry.
    localparam int STACK_DEPTH = 512;
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int NEST_W      = 10;
    localparam logic [NEST_W-1:0] NEST_RESET = NEST_W'(512);

    // Parser modes.
    typedef enum logic [4:0] {
        M_VAL, M_ARR_FIRST, M_OBJ_FIRST, M_OBJ_KEY, M_COLON, M_AFTER,
        M_STR, M_ESC, M_HEX, M_LOW_BS, M_LOW_U, M_LOW_HEX, M_LIT,
        M_N_SIGN, M_N_ZERO, M_N_INT, M_N_DOT, M_N_FRAC, M_N_E, M_N_ESIGN, M_N_EXP
    } mode_t;

    // Fault classes reported with the verdict.
    typedef enum logic [3:0] {
        F_NONE, F_UNEXPECTED, F_LITERAL, F_NUMBER, F_ESCAPE, F_UNICODE,
        F_CONTROL, F_TOO_DEEP, F_ENDED_EARLY, F_TRAILING
    } fault_t;

    // Literal kinds.
    typedef enum logic [1:0] {
        LIT_TRUE, LIT_FALSE, LIT_NULL
    } lit_t;

    // Expected character of a literal at a given position.
    function automatic logic [7:0] lit_char(input lit_t kind, input logic [2:0] idx);
        logic [7:0] ch;
        ch = 8'h00;
        case (kind)
            LIT_TRUE:
            begin
                case (idx)
                    3'd0: ch = "t";
                    3'd1: ch = "r";
                    3'd2: ch = "u";
                    3'd3: ch = "e";
                    default: ch = 8'h00;
                endcase
            end
            LIT_FALSE:
            begin
                case (idx)
                    3'd0: ch = "f";
                    3'd1: ch = "a";
                    3'd2: ch = "l";
                    3'd3: ch = "s";
                    3'd4: ch = "e";
                    default: ch = 8'h00;
                endcase
            end
            default:
            begin
                case (idx)
                    3'd0: ch = "n";
                    3'd1: ch = "u";
                    3'd2: ch = "l";
                    3'd3: ch = "l";
                    default: ch = 8'h00;
                endcase
            end
        endcase
        return ch;
    endfunction

    // Length of a literal.
    function automatic logic [2:0] lit_len(input lit_t kind);
        return (kind == LIT_FALSE) ? 3'd5 : 3'd4;
    endfunction

endpackage

### rtl/core/jdv_byte_if.sv
// Byte stream channel.
interface jdv_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_byte;

    modport source (output valid, in_byte, last_byte, input ready);
    modport sink (input valid, in_byte, last_byte, output ready);
endinterface

### rtl/core/jdv_verdict_if.sv
// Verdict channel.
interface jdv_verdict_if;
    logic       valid;
    logic       ready;
    logic       doc_valid;
    logic [3:0] fault_kind;

    modport source (output valid, doc_valid, fault_kind, input ready);
    modport sink (input valid, doc_valid, fault_kind, output ready);
endinterface

### rtl/core/jdv_stack.sv
// Container stack: one bit per open level, one write and one registered read per cycle.
module jdv_stack
(
    input  logic                       clk,
    input  logic                       we,
    input  logic [jdv_pkg::ADDR_W-1:0] waddr,
    input  logic                       wdata,
    input  logic [jdv_pkg::ADDR_W-1:0] raddr,
    output logic                       rdata
);

    logic mem [jdv_pkg::STACK_DEPTH];
    logic rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/json_document_validator.sv
// Streaming JSON document validator.
// The byte channel carries one document byte per transaction, with last_byte
// set on the final byte. The verdict channel carries one transaction per
// document: doc_valid and the class of the first fault found.
// One byte is taken every cycle. The verdict is registered and appears on the
// cycle after the final byte is accepted. The nesting stack lives in a
// 512 x 1 synchronous memory; the top entry is held in a register and the one
// below it is prefetched every cycle, so a pop never stalls the stream.
// The configuration write (cfg_we, cfg_wdata) sets the deepest allowed
// nesting; the user is to make it only while the block is idle, as the block
// does not enforce it. Values above the stack size saturate to the stack size.
// Reset returns the parser to its start state, empties the verdict register
// and sets the nesting limit to 512. The stack memory needs no clearing.
// If the receiver stalls a pending verdict, the byte channel stops accepting
// until the verdict is taken.
module json_document_validator
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [jdv_pkg::NEST_W-1:0]    cfg_wdata,
    jdv_byte_if.sink                      byte_ch,
    jdv_verdict_if.source                 verdict_ch
);

    jdv_pkg::mode_t  mode_reg, mode_next;
    jdv_pkg::fault_t fault_reg, fault_next;
    jdv_pkg::lit_t   lit_kind_reg, lit_kind_next;
    logic [jdv_pkg::DEPTH_W-1:0] depth_reg, depth_next;
    logic [jdv_pkg::NEST_W-1:0]  max_nest_reg;
    logic        top_reg, top_next;
    logic        key_reg, key_next;
    logic [2:0]  lit_idx_reg, lit_idx_next;
    logic [2:0]  hex_cnt_reg, hex_cnt_next;
    logic [15:0] hex_val_reg, hex_val_next;
    logic        out_valid_reg;
    logic        out_doc_reg;
    jdv_pkg::fault_t out_fault_reg;

    logic        accept;
    logic [7:0]  c;
    logic        ws, is_dig, hex_ok;
    logic [3:0]  hex_d;
    logic [15:0] hex_new;
    logic        do_start, do_after, do_push, do_pop, push_obj;
    logic        stk_we;
    logic        stk_rd;
    logic        at_limit;
    logic        done;
    logic [31:0] lim;
    logic [jdv_pkg::DEPTH_W-1:0] rd_depth;
    jdv_pkg::fault_t final_fault;

    assign c      = byte_ch.in_byte;
    assign accept = byte_ch.valid && byte_ch.ready;
    assign byte_ch.ready = !out_valid_reg || verdict_ch.ready;

    // Character classes.
    always_comb
    begin
        ws     = (c == " ") || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
        is_dig = (c >= "0") && (c <= "9");
        hex_ok = 1'b1;
        hex_d  = 4'd0;
        if (is_dig)
        begin
            hex_d = 4'(c - "0");
        end
        else if ((c >= "a") && (c <= "f"))
        begin
            hex_d = 4'(c - "a" + 8'd10);
        end
        else if ((c >= "A") && (c <= "F"))
        begin
            hex_d = 4'(c - "A" + 8'd10);
        end
        else
        begin
            hex_ok = 1'b0;
        end
        hex_new = {hex_val_reg[11:0], hex_d};
    end

    // Effective nesting limit, saturated to the stack size.
    assign lim = (32'(max_nest_reg) > 32'(jdv_pkg::STACK_DEPTH)) ?
                 32'(jdv_pkg::STACK_DEPTH) : 32'(max_nest_reg);
    assign at_limit = 32'(depth_reg) >= lim;

    // Next-state logic for one byte.
    always_comb
    begin
        mode_next     = mode_reg;
        fault_next    = fault_reg;
        lit_kind_next = lit_kind_reg;
        depth_next    = depth_reg;
        top_next      = top_reg;
        key_next      = key_reg;
        lit_idx_next  = lit_idx_reg;
        hex_cnt_next  = hex_cnt_reg;
        hex_val_next  = hex_val_reg;
        do_start = 1'b0;
        do_after = 1'b0;
        do_push  = 1'b0;
        do_pop   = 1'b0;
        push_obj = 1'b0;
        stk_we   = 1'b0;

        if (accept && (fault_reg == jdv_pkg::F_NONE))
        begin
            case (mode_reg)
                jdv_pkg::M_VAL:
                begin
                    do_start = !ws;
                end
                jdv_pkg::M_ARR_FIRST:
                begin
                    if (!ws)
                    begin
                        if (c == "]") do_pop = 1'b1;
                        else do_start = 1'b1;
                    end
                end
                jdv_pkg::M_OBJ_FIRST, jdv_pkg::M_OBJ_KEY:
                begin
                    if (!ws)
                    begin
                        if ((c == "}") && (mode_reg == jdv_pkg::M_OBJ_FIRST))
                        begin
                            do_pop = 1'b1;
                        end
                        else if (c == 8'h22)
                        begin
                            key_next  = 1'b1;
                            mode_next = jdv_pkg::M_STR;
                        end
                        else
                        begin
                            fault_next = jdv_pkg::F_UNEXPECTED;
                        end
                    end
                end
                jdv_pkg::M_COLON:
                begin
                    if (!ws)
                    begin
                        if (c == ":") mode_next = jdv_pkg::M_VAL;
                        else fault_next = jdv_pkg::F_UNEXPECTED;
                    end
                end
                jdv_pkg::M_AFTER:
                begin
                    do_after = 1'b1;
                end
                jdv_pkg::M_STR:
                begin
                    if (c == 8'h22)
                    begin
                        mode_next = key_reg ? jdv_pkg::M_COLON : jdv_pkg::M_AFTER;
                    end
                    else if (c == 8'h5C)
                    begin
                        mode_next = jdv_pkg::M_ESC;
                    end
                    else if (c < 8'h20)
                    begin
                        fault_next = jdv_pkg::F_CONTROL;
                    end
                end
                jdv_pkg::M_ESC:
                begin
                    if ((c == 8'h22) || (c == 8'h5C) || (c == "/") || (c == "b") ||
                        (c == "f") || (c == "n") || (c == "r") || (c == "t"))
                    begin
                        mode_next = jdv_pkg::M_STR;
                    end
                    else if (c == "u")
                    begin
                        hex_cnt_next = 3'd0;
                        hex_val_next = 16'd0;
                        mode_next    = jdv_pkg::M_HEX;
                    end
                    else
                    begin
                        fault_next = jdv_pkg::F_ESCAPE;
                    end
                end
                jdv_pkg::M_HEX, jdv_pkg::M_LOW_HEX:
                begin
                    if (!hex_ok)
                    begin
                        fault_next = (mode_reg == jdv_pkg::M_HEX) ?
                                     jdv_pkg::F_ESCAPE : jdv_pkg::F_UNICODE;
                    end
                    else
                    begin
                        hex_val_next = hex_new;
                        hex_cnt_next = hex_cnt_reg + 3'd1;
                        if (hex_cnt_reg == 3'd3)
                        begin
                            if (mode_reg == jdv_pkg::M_HEX)
                            begin
                                mode_next = ((hex_new >= 16'hD800) && (hex_new <= 16'hDBFF)) ?
                                            jdv_pkg::M_LOW_BS : jdv_pkg::M_STR;
                            end
                            else if ((hex_new < 16'hDC00) || (hex_new > 16'hDFFF))
                            begin
                                fault_next = jdv_pkg::F_UNICODE;
                            end
                            else
                            begin
                                mode_next = jdv_pkg::M_STR;
                            end
                        end
                    end
                end
                jdv_pkg::M_LOW_BS:
                begin
                    if (c == 8'h5C) mode_next = jdv_pkg::M_LOW_U;
                    else fault_next = jdv_pkg::F_UNICODE;
                end
                jdv_pkg::M_LOW_U:
                begin
                    if (c == "u")
                    begin
                        hex_cnt_next = 3'd0;
                        hex_val_next = 16'd0;
                        mode_next    = jdv_pkg::M_LOW_HEX;
                    end
                    else
                    begin
                        fault_next = jdv_pkg::F_UNICODE;
                    end
                end
                jdv_pkg::M_LIT:
                begin
                    if ((lit_idx_reg >= jdv_pkg::lit_len(lit_kind_reg)) ||
                        (c != jdv_pkg::lit_char(lit_kind_reg, lit_idx_reg)))
                    begin
                        fault_next = jdv_pkg::F_LITERAL;
                    end
                    else
                    begin
                        lit_idx_next = lit_idx_reg + 3'd1;
                        if ((lit_idx_reg + 3'd1) == jdv_pkg::lit_len(lit_kind_reg))
                        begin
                            mode_next = jdv_pkg::M_AFTER;
                        end
                    end
                end
                jdv_pkg::M_N_SIGN:
                begin
                    if (c == "0") mode_next = jdv_pkg::M_N_ZERO;
                    else if (is_dig) mode_next = jdv_pkg::M_N_INT;
                    else fault_next = jdv_pkg::F_NUMBER;
                end
                jdv_pkg::M_N_ZERO, jdv_pkg::M_N_INT:
                begin
                    if (is_dig && (mode_reg == jdv_pkg::M_N_INT))
                    begin
                        mode_next = mode_reg;
                    end
                    else if (c == ".")
                    begin
                        mode_next = jdv_pkg::M_N_DOT;
                    end
                    else if ((c == "e") || (c == "E"))
                    begin
                        mode_next = jdv_pkg::M_N_E;
                    end
                    else
                    begin
                        mode_next = jdv_pkg::M_AFTER;
                        do_after  = 1'b1;
                    end
                end
                jdv_pkg::M_N_DOT:
                begin
                    if (is_dig) mode_next = jdv_pkg::M_N_FRAC;
                    else fault_next = jdv_pkg::F_NUMBER;
                end
                jdv_pkg::M_N_FRAC:
                begin
                    if (is_dig)
                    begin
                        mode_next = mode_reg;
                    end
                    else if ((c == "e") || (c == "E"))
                    begin
                        mode_next = jdv_pkg::M_N_E;
                    end
                    else
                    begin
                        mode_next = jdv_pkg::M_AFTER;
                        do_after  = 1'b1;
                    end
                end
                jdv_pkg::M_N_E:
                begin
                    if ((c == "+") || (c == "-")) mode_next = jdv_pkg::M_N_ESIGN;
                    else if (is_dig) mode_next = jdv_pkg::M_N_EXP;
                    else fault_next = jdv_pkg::F_NUMBER;
                end
                jdv_pkg::M_N_ESIGN:
                begin
                    if (is_dig) mode_next = jdv_pkg::M_N_EXP;
                    else fault_next = jdv_pkg::F_NUMBER;
                end
                jdv_pkg::M_N_EXP:
                begin
                    if (!is_dig)
                    begin
                        mode_next = jdv_pkg::M_AFTER;
                        do_after  = 1'b1;
                    end
                end
                default:
                begin
                    fault_next = jdv_pkg::F_UNEXPECTED;
                end
            endcase

            // Separator or closer after a complete value.
            if (do_after && !ws)
            begin
                if (depth_reg == '0)
                begin
                    fault_next = jdv_pkg::F_TRAILING;
                end
                else if (top_reg)
                begin
                    if (c == ",") mode_next = jdv_pkg::M_OBJ_KEY;
                    else if (c == "}") do_pop = 1'b1;
                    else fault_next = jdv_pkg::F_UNEXPECTED;
                end
                else
                begin
                    if (c == ",") mode_next = jdv_pkg::M_VAL;
                    else if (c == "]") do_pop = 1'b1;
                    else fault_next = jdv_pkg::F_UNEXPECTED;
                end
            end

            // First byte of a value.
            if (do_start)
            begin
                case (c)
                    8'h22:
                    begin
                        key_next  = 1'b0;
                        mode_next = jdv_pkg::M_STR;
                    end
                    "{":
                    begin
                        do_push  = 1'b1;
                        push_obj = 1'b1;
                    end
                    "[":
                    begin
                        do_push = 1'b1;
                    end
                    "t", "f", "n":
                    begin
                        lit_kind_next = (c == "t") ? jdv_pkg::LIT_TRUE :
                                        (c == "f") ? jdv_pkg::LIT_FALSE : jdv_pkg::LIT_NULL;
                        lit_idx_next  = 3'd1;
                        mode_next     = jdv_pkg::M_LIT;
                    end
                    "-":
                    begin
                        mode_next = jdv_pkg::M_N_SIGN;
                    end
                    "0":
                    begin
                        mode_next = jdv_pkg::M_N_ZERO;
                    end
                    default:
                    begin
                        if (is_dig) mode_next = jdv_pkg::M_N_INT;
                        else fault_next = jdv_pkg::F_UNEXPECTED;
                    end
                endcase
            end

            // Stack push with the depth check.
            if (do_push)
            begin
                if (at_limit)
                begin
                    fault_next = jdv_pkg::F_TOO_DEEP;
                end
                else
                begin
                    stk_we     = 1'b1;
                    depth_next = depth_reg + 1'b1;
                    top_next   = push_obj;
                    mode_next  = push_obj ? jdv_pkg::M_OBJ_FIRST : jdv_pkg::M_ARR_FIRST;
                end
            end

            // Stack pop; the entry below the top was prefetched last cycle.
            if (do_pop)
            begin
                if (depth_reg != '0) depth_next = depth_reg - 1'b1;
                top_next  = stk_rd;
                mode_next = jdv_pkg::M_AFTER;
            end
        end
    end

    // End-of-document check.
    always_comb
    begin
        done = (depth_next == '0) &&
               ((mode_next == jdv_pkg::M_AFTER) || (mode_next == jdv_pkg::M_N_ZERO) ||
                (mode_next == jdv_pkg::M_N_INT) || (mode_next == jdv_pkg::M_N_FRAC) ||
                (mode_next == jdv_pkg::M_N_EXP));
        final_fault = fault_next;
        if ((fault_next == jdv_pkg::F_NONE) && !done)
        begin
            final_fault = jdv_pkg::F_ENDED_EARLY;
        end
    end

    // Prefetch the entry that becomes the top after a pop next cycle.
    assign rd_depth = depth_next - jdv_pkg::DEPTH_W'(2);

    jdv_stack u_stack
    (
        .clk   (clk),
        .we    (stk_we),
        .waddr (depth_reg[jdv_pkg::ADDR_W-1:0]),
        .wdata (push_obj),
        .raddr (rd_depth[jdv_pkg::ADDR_W-1:0]),
        .rdata (stk_rd)
    );

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_nest_reg <= jdv_pkg::NEST_RESET;
        end
        else if (cfg_we)
        begin
            max_nest_reg <= cfg_wdata;
        end
    end

    // Parser state; cleared after the final byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= jdv_pkg::M_VAL;
            fault_reg    <= jdv_pkg::F_NONE;
            lit_kind_reg <= jdv_pkg::LIT_TRUE;
            depth_reg    <= '0;
            top_reg      <= 1'b0;
            key_reg      <= 1'b0;
            lit_idx_reg  <= 3'd0;
            hex_cnt_reg  <= 3'd0;
            hex_val_reg  <= 16'd0;
        end
        else if (accept && byte_ch.last_byte)
        begin
            mode_reg     <= jdv_pkg::M_VAL;
            fault_reg    <= jdv_pkg::F_NONE;
            lit_kind_reg <= jdv_pkg::LIT_TRUE;
            depth_reg    <= '0;
            top_reg      <= 1'b0;
            key_reg      <= 1'b0;
            lit_idx_reg  <= 3'd0;
            hex_cnt_reg  <= 3'd0;
            hex_val_reg  <= 16'd0;
        end
        else
        begin
            mode_reg     <= mode_next;
            fault_reg    <= fault_next;
            lit_kind_reg <= lit_kind_next;
            depth_reg    <= depth_next;
            top_reg      <= top_next;
            key_reg      <= key_next;
            lit_idx_reg  <= lit_idx_next;
            hex_cnt_reg  <= hex_cnt_next;
            hex_val_reg  <= hex_val_next;
        end
    end

    // Verdict output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept && byte_ch.last_byte)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (verdict_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && byte_ch.last_byte)
        begin
            out_doc_reg   <= (final_fault == jdv_pkg::F_NONE);
            out_fault_reg <= final_fault;
        end
    end

    assign verdict_ch.valid      = out_valid_reg;
    assign verdict_ch.doc_valid  = out_doc_reg;
    assign verdict_ch.fault_kind = out_fault_reg;

endmodule

### rtl/core/jdv_checker.sv
// Port-level checks for the validator.
module jdv_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       in_last,
    input logic       out_valid,
    input logic       out_ready,
    input logic       doc_valid,
    input logic [3:0] fault_kind
);

    // A verdict says valid exactly when no fault is reported.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (doc_valid == (fault_kind == jdv_pkg::F_NONE)))
    else $error("doc_valid disagrees with fault_kind");

    // Fault classes stay within the defined range.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (fault_kind <= jdv_pkg::F_TRAILING))
    else $error("fault_kind out of range");

    // A verdict follows every accepted final byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_last) |=> out_valid)
    else $error("missing verdict after final byte");

    // A pending verdict holds until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(fault_kind)))
    else $error("verdict dropped while stalled");

    // A stalled verdict stops the byte stream.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
    else $error("byte accepted past a stalled verdict");

endmodule

bind json_document_validator jdv_checker u_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (byte_ch.valid),
    .in_ready   (byte_ch.ready),
    .in_last    (byte_ch.last_byte),
    .out_valid  (verdict_ch.valid),
    .out_ready  (verdict_ch.ready),
    .doc_valid  (verdict_ch.doc_valid),
    .fault_kind (verdict_ch.fault_kind)
);
